/* rtl/assert_macros.svh */
// Assertion macros included by terminated_line_assembler.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/tla_pkg.sv */
`timescale 1ns / 1ps
package tla_pkg;
	localparam int MAX_TERM = 4;
	localparam int TERM_LIM = (MAX_TERM < 4) ? MAX_TERM : 4;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [1:0] ST_STORED   = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_TIMEOUT  = 2'd3;

	localparam logic [1:0] REG_TERM_BYTES    = 2'd0;
	localparam logic [1:0] REG_TERM_LEN      = 2'd1;
	localparam logic [1:0] REG_MAX_LEN       = 2'd2;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

	localparam logic [31:0] TERM_BYTES_RST    = 32'h0000_0A0D;
	localparam logic [2:0]  TERM_LEN_RST      = 3'd2;
	localparam logic [7:0]  MAX_LEN_RST       = 8'd255;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10;

	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	function automatic logic [2:0] eff_term_len(input logic [2:0] len);
		logic [2:0] n;
		n = len;
		if (n == 3'd0)
			n = 3'd1;
		if (n > 3'(TERM_LIM))
			n = 3'(TERM_LIM);
		return n;
	endfunction
endpackage

/* rtl/tla_if.sv */
`timescale 1ns / 1ps
interface tla_byte_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_in;

	modport source (output valid, output cmd, output data_in, input ready);
	modport sink (input valid, input cmd, input data_in, output ready);
endinterface

interface tla_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] data_out;
	logic [7:0] length;

	modport source (output valid, output status, output data_out, output length, input ready);
	modport sink (input valid, input status, input data_out, input length, output ready);
endinterface

/* rtl/terminated_line_assembler.sv */
// Channel   Direction  Contents
// bytes     in         cmd, data_in
// results   out        status, data_out, length
// cfg_*     in         write enable, register index, write data
//
// Each request is taken into an input register and processed from there, one per cycle while no
// result stalls. A result is then offered from the output register; requests with no result
// vanish. The output register lets a new request enter while a result waits to be taken.
// A stalled result stops processing, and the input then takes at most one more request;
// reset restores the register defaults and leaves the block idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module terminated_line_assembler (
	input logic                clk,
	input logic                arst_n,
	tla_byte_if.sink           bytes,
	tla_result_if.source       results,
	input logic                cfg_we,
	input logic [1:0]          cfg_idx,
	input logic [31:0]         cfg_data
);
	logic [31:0] term_bytes_q;
	logic [2:0]  term_len_q;
	logic [7:0]  max_len_q;
	logic [15:0] timeout_ticks_q;

	logic        active_q;
	logic [7:0]  byte_count_q;
	logic [15:0] elapsed_q;
	logic [31:0] recent_q;

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [7:0]  data_s1;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  data_out_q;
	logic [7:0]  length_q;

	logic        advance;
	logic        res_valid;
	logic [1:0]  res_status;
	logic [7:0]  res_data;
	logic [7:0]  res_length;
	logic        active_d;
	logic [7:0]  count_d;
	logic [15:0] elapsed_d;
	logic [31:0] recent_d;
	logic [2:0]  n_term;
	logic [7:0]  count_inc;
	logic [31:0] recent_shift;
	logic [15:0] elapsed_inc;
	logic        suffix_ok;

	assign advance       = valid_s1 && (!out_valid_q || results.ready);
	assign bytes.ready   = !valid_s1 || advance;
	assign n_term        = tla_pkg::eff_term_len(term_len_q);
	assign count_inc     = byte_count_q + 8'd1;
	assign recent_shift  = {recent_q[23:0], data_s1};
	assign elapsed_inc   = (elapsed_q == tla_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;

	always_comb begin
		suffix_ok = (count_inc >= {5'd0, n_term});
		for (int i = 0; i < 4; i++) begin
			if ((3'(i) < n_term) && (recent_shift[8*i +: 8] != term_bytes_q[8*i +: 8]))
				suffix_ok = 1'b0;
		end
	end

	always_comb begin
		res_valid  = 1'b0;
		res_status = tla_pkg::ST_STORED;
		res_data   = 8'd0;
		res_length = byte_count_q;
		active_d   = active_q;
		count_d    = byte_count_q;
		elapsed_d  = elapsed_q;
		recent_d   = recent_q;
		unique case (cmd_s1)
			tla_pkg::CMD_START: begin
				count_d    = 8'd0;
				elapsed_d  = 16'd0;
				recent_d   = 32'd0;
				active_d   = (timeout_ticks_q != 16'd0);
				res_valid  = (timeout_ticks_q == 16'd0);
				res_status = tla_pkg::ST_TIMEOUT;
				res_length = 8'd0;
			end
			tla_pkg::CMD_BYTE: begin
				if (active_q) begin
					res_valid = 1'b1;
					if (byte_count_q >= max_len_q) begin
						active_d   = 1'b0;
						res_status = tla_pkg::ST_FULL;
					end else begin
						count_d    = count_inc;
						recent_d   = recent_shift;
						res_data   = data_s1;
						res_length = count_inc;
						res_status = suffix_ok ? tla_pkg::ST_COMPLETE : tla_pkg::ST_STORED;
						active_d   = !suffix_ok;
					end
				end
			end
			tla_pkg::CMD_TICK: begin
				if (active_q) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= timeout_ticks_q) begin
						active_d   = 1'b0;
						res_valid  = 1'b1;
						res_status = tla_pkg::ST_TIMEOUT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_bytes_q    <= tla_pkg::TERM_BYTES_RST;
			term_len_q      <= tla_pkg::TERM_LEN_RST;
			max_len_q       <= tla_pkg::MAX_LEN_RST;
			timeout_ticks_q <= tla_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tla_pkg::REG_TERM_BYTES:    term_bytes_q    <= cfg_data;
				tla_pkg::REG_TERM_LEN:      term_len_q      <= cfg_data[2:0];
				tla_pkg::REG_MAX_LEN:       max_len_q       <= cfg_data[7:0];
				tla_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			active_q     <= 1'b0;
			byte_count_q <= 8'd0;
			elapsed_q    <= 16'd0;
			recent_q     <= 32'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (bytes.ready)
				valid_s1 <= bytes.valid;
			if (advance) begin
				active_q     <= active_d;
				byte_count_q <= count_d;
				elapsed_q    <= elapsed_d;
				recent_q     <= recent_d;
			end
			if (advance && res_valid)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			cmd_s1  <= bytes.cmd;
			data_s1 <= bytes.data_in;
		end
		if (advance && res_valid) begin
			status_q   <= res_status;
			data_out_q <= res_data;
			length_q   <= res_length;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.status   = status_q;
	assign results.data_out = data_out_q;
	assign results.length   = length_q;

	`ASSERT_NEXT(a_zero_timeout, clk, arst_n,
		advance && cmd_s1 == tla_pkg::CMD_START && timeout_ticks_q == 16'd0,
		out_valid_q && status_q == tla_pkg::ST_TIMEOUT && length_q == 8'd0)
	`ASSERT_NEXT(a_end_goes_idle, clk, arst_n,
		advance && res_valid && res_status != tla_pkg::ST_STORED, !active_q)
	`ASSERT_HOLDS(a_no_data_on_abort, clk, arst_n,
		!(out_valid_q && (status_q == tla_pkg::ST_FULL || status_q == tla_pkg::ST_TIMEOUT))
		|| data_out_q == 8'd0)
endmodule

/* tb/sv/tb_terminated_line_assembler.sv */
`timescale 1ns / 1ps
module tb_terminated_line_assembler;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data;
		logic [7:0] length;
	} line_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [31:0] cfg_data;

	tla_byte_if   byte_chan();
	tla_result_if result_chan();

	terminated_line_assembler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (byte_chan),
		.results  (result_chan),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Configuration as last written.
	logic [31:0] term_pattern;
	logic [2:0]  term_width;
	logic [7:0]  line_limit;
	logic [15:0] tick_limit;

	// Session state of the line being assembled.
	logic        session_open;
	logic [7:0]  line_count;
	logic [15:0] tick_count;
	logic [31:0] last_bytes;

	line_result_t pending_results[$];

	logic failed = 1'b0;
	logic steady;
	int   items_sent;
	int   cycle_count = 0;
	int   hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("terminated_line_assembler verification failed");
			$finish;
		end
	end

	function automatic int active_term_width();
		int n;
		n = int'(term_width);
		if (n < 1)
			n = 1;
		if (n > tla_pkg::TERM_LIM)
			n = tla_pkg::TERM_LIM;
		return n;
	endfunction

	task automatic push_result(input logic [1:0] st, input logic [7:0] d, input logic [7:0] len);
		line_result_t r;
		r.status = st;
		r.data = d;
		r.length = len;
		pending_results.push_back(r);
	endtask

	task automatic predict_line_event(input logic [1:0] op, input logic [7:0] value);
		int n;
		logic [31:0] mask;
		if (op == tla_pkg::CMD_START) begin
			session_open = 1'b1;
			line_count = 8'd0;
			tick_count = 16'd0;
			last_bytes = 32'd0;
			if (tick_limit == 16'd0) begin
				session_open = 1'b0;
				push_result(tla_pkg::ST_TIMEOUT, 8'd0, 8'd0);
			end
		end else if (session_open && op == tla_pkg::CMD_BYTE) begin
			if (line_count >= line_limit) begin
				session_open = 1'b0;
				push_result(tla_pkg::ST_FULL, 8'd0, line_count);
			end else begin
				line_count = line_count + 8'd1;
				last_bytes = {last_bytes[23:0], value};
				n = active_term_width();
				mask = (n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
				if (line_count >= n && (last_bytes & mask) == (term_pattern & mask)) begin
					session_open = 1'b0;
					push_result(tla_pkg::ST_COMPLETE, value, line_count);
				end else begin
					push_result(tla_pkg::ST_STORED, value, line_count);
				end
			end
		end else if (session_open && op == tla_pkg::CMD_TICK) begin
			if (tick_count != tla_pkg::ELAPSED_MAX)
				tick_count = tick_count + 16'd1;
			if (tick_count >= tick_limit) begin
				session_open = 1'b0;
				push_result(tla_pkg::ST_TIMEOUT, 8'd0, line_count);
			end
		end
	endtask

	task automatic send_request(input logic [1:0] op, input logic [7:0] value);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			byte_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_chan.valid <= 1'b1;
		byte_chan.cmd <= op;
		byte_chan.data_in <= value;
		@(posedge clk);
		while (!byte_chan.ready) @(posedge clk);
		predict_line_event(op, value);
		items_sent++;
	endtask

	task automatic drain_results();
		byte_chan.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [31:0] term, input logic [2:0] width,
			input logic [7:0] limit, input logic [15:0] ticks);
		drain_results();
		cfg_we <= 1'b1;
		cfg_idx <= tla_pkg::REG_TERM_BYTES;
		cfg_data <= term;
		@(posedge clk);
		cfg_idx <= tla_pkg::REG_TERM_LEN;
		cfg_data <= {29'd0, width};
		@(posedge clk);
		cfg_idx <= tla_pkg::REG_MAX_LEN;
		cfg_data <= {24'd0, limit};
		@(posedge clk);
		cfg_idx <= tla_pkg::REG_TIMEOUT_TICKS;
		cfg_data <= {16'd0, ticks};
		@(posedge clk);
		cfg_we <= 1'b0;
		term_pattern = term;
		term_width = width;
		line_limit = limit;
		tick_limit = ticks;
	endtask

	// Every result is checked against the oldest prediction; the ready stall is drawn per result.
	always @(posedge clk) begin
		line_result_t want;
		if (result_chan.valid && result_chan.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d data_out %0d length %0d",
					result_chan.status, result_chan.data_out, result_chan.length);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (result_chan.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_chan.status);
					failed = 1'b1;
				end
				if (result_chan.data_out !== want.data) begin
					$error("data_out: expected %0d, got %0d", want.data, result_chan.data_out);
					failed = 1'b1;
				end
				if (result_chan.length !== want.length) begin
					$error("length: expected %0d, got %0d", want.length, result_chan.length);
					failed = 1'b1;
				end
			end
			hold_left = steady ? 0 : $urandom_range(0, 14);
			if (hold_left > 0)
				result_chan.ready <= 1'b0;
		end else if (!result_chan.ready) begin
			if (hold_left > 0)
				hold_left = hold_left - 1;
			if (hold_left == 0)
				result_chan.ready <= 1'b1;
		end
	end

	task automatic test_default_terminator();
		send_request(tla_pkg::CMD_BYTE, 8'h41);
		send_request(tla_pkg::CMD_TICK, 8'h00);
		send_request(CMD_UNUSED, 8'hFF);
		send_request(tla_pkg::CMD_START, 8'h00);
		send_request(tla_pkg::CMD_BYTE, 8'h00);
		send_request(tla_pkg::CMD_BYTE, 8'hFF);
		send_request(tla_pkg::CMD_BYTE, 8'h0D);
		send_request(tla_pkg::CMD_BYTE, 8'h0A);
	endtask

	task automatic test_short_line();
		apply_config(32'h0000_0000, 3'd4, 8'd255, 16'd100);
		send_request(tla_pkg::CMD_START, 8'hFF);
		repeat (4) send_request(tla_pkg::CMD_BYTE, 8'h00);
	endtask

	task automatic test_session_control();
		apply_config(32'h0000_0A0D, 3'd2, 8'd255, 16'd0);
		send_request(tla_pkg::CMD_START, 8'h00);
		apply_config(32'h0000_0A0D, 3'd2, 8'd255, 16'd3);
		send_request(tla_pkg::CMD_TICK, 8'h00);
		send_request(tla_pkg::CMD_START, 8'h00);
		send_request(tla_pkg::CMD_BYTE, 8'h31);
		send_request(tla_pkg::CMD_START, 8'h00);
		send_request(tla_pkg::CMD_BYTE, 8'h32);
		repeat (3) send_request(tla_pkg::CMD_TICK, 8'h00);
		send_request(tla_pkg::CMD_TICK, 8'h00);
		send_request(CMD_UNUSED, 8'h00);
	endtask

	task automatic test_buffer_limits();
		apply_config(32'hFFFF_FFFF, 3'd7, 8'd0, 16'hFFFF);
		send_request(tla_pkg::CMD_START, 8'h00);
		send_request(tla_pkg::CMD_BYTE, 8'hFF);
		apply_config(32'h0000_0055, 3'd0, 8'd3, 16'hFFFF);
		send_request(tla_pkg::CMD_START, 8'h00);
		send_request(tla_pkg::CMD_BYTE, 8'h55);
		send_request(tla_pkg::CMD_START, 8'h00);
		send_request(tla_pkg::CMD_BYTE, 8'hAA);
		send_request(tla_pkg::CMD_BYTE, 8'h12);
		send_request(tla_pkg::CMD_BYTE, 8'h34);
		send_request(tla_pkg::CMD_BYTE, 8'h56);
		apply_config(32'hFFFF_FFFF, 3'd7, 8'd4, 16'hFFFF);
		send_request(tla_pkg::CMD_START, 8'h00);
		repeat (4) send_request(tla_pkg::CMD_BYTE, 8'hFF);
	endtask

	task automatic test_longest_line();
		int k;
		apply_config(32'h0000_0A0D, 3'd2, 8'd255, 16'hFFFF);
		send_request(tla_pkg::CMD_START, 8'h00);
		for (k = 0; k < 255; k++)
			send_request(tla_pkg::CMD_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
		send_request(tla_pkg::CMD_BYTE, 8'h0A);
	endtask

	task automatic random_line();
		int len;
		int n;
		int k;
		logic [1:0] op;
		logic [7:0] b;
		steady = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 7) == 0) begin
			op = 2'($urandom_range(0, 3));
			b = 8'($urandom);
			send_request(op, b);
		end
		send_request(tla_pkg::CMD_START, 8'($urandom));
		if (line_limit <= 8'd40 && $urandom_range(0, 3) == 0)
			len = $urandom_range(0, int'(line_limit) + 2);
		else
			len = $urandom_range(0, 12);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 7) == 0)
				send_request(tla_pkg::CMD_TICK, 8'($urandom));
			if ($urandom_range(0, 2) == 0)
				b = term_pattern[8 * $urandom_range(0, 3) +: 8];
			else
				b = 8'($urandom);
			send_request(tla_pkg::CMD_BYTE, b);
		end
		if ($urandom_range(0, 9) < 6) begin
			n = active_term_width();
			for (k = n - 1; k >= 0; k--)
				send_request(tla_pkg::CMD_BYTE, term_pattern[8 * k +: 8]);
		end
		if ($urandom_range(0, 19) == 0)
			drain_results();
	endtask

	task automatic test_random_lines();
		logic [31:0] term;
		logic [2:0]  width;
		logic [7:0]  limit;
		logic [15:0] ticks;
		int phase;
		int base;
		base = items_sent;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					term = 32'hFFFF_FFFF;
					width = 3'd4;
					limit = 8'd255;
					ticks = 16'hFFFF;
				end
				1: begin
					term = 32'h0000_0000;
					width = 3'd1;
					limit = 8'd1;
					ticks = 16'd1;
				end
				default: begin
					term = $urandom;
					if ($urandom_range(0, 2) == 0)
						term = {4{term[7:0]}};
					width = 3'($urandom_range(0, 7));
					case ($urandom_range(0, 3))
						0: limit = 8'($urandom_range(1, 8));
						1: limit = 8'($urandom_range(9, 40));
						2: limit = 8'd255;
						default: limit = 8'($urandom_range(0, 255));
					endcase
					case ($urandom_range(0, 4))
						0: ticks = 16'd0;
						1: ticks = 16'($urandom_range(1, 8));
						2: ticks = 16'($urandom_range(9, 200));
						default: ticks = 16'($urandom_range(201, 65535));
					endcase
				end
			endcase
			apply_config(term, width, limit, ticks);
			while (items_sent < base + RANDOM_ITEMS * (phase + 1) / 8)
				random_line();
		end
		steady = 1'b0;
	endtask

	task automatic test_timeout_boundary();
		apply_config(32'h0000_0A0D, 3'd2, 8'd255, 16'd20);
		steady = 1'b1;
		send_request(tla_pkg::CMD_START, 8'h00);
		repeat (19) send_request(tla_pkg::CMD_TICK, 8'h00);
		send_request(tla_pkg::CMD_BYTE, 8'h41);
		send_request(tla_pkg::CMD_TICK, 8'h00);
		send_request(tla_pkg::CMD_TICK, 8'h00);
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = tla_pkg::REG_TERM_BYTES;
		cfg_data = 32'd0;
		byte_chan.valid = 1'b0;
		byte_chan.cmd = tla_pkg::CMD_TICK;
		byte_chan.data_in = 8'd0;
		result_chan.ready = 1'b0;
		term_pattern = tla_pkg::TERM_BYTES_RST;
		term_width = tla_pkg::TERM_LEN_RST;
		line_limit = tla_pkg::MAX_LEN_RST;
		tick_limit = tla_pkg::TIMEOUT_TICKS_RST;
		session_open = 1'b0;
		line_count = 8'd0;
		tick_count = 16'd0;
		last_bytes = 32'd0;
		steady = 1'b0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_terminator();
		test_short_line();
		test_session_control();
		test_buffer_limits();
		test_longest_line();
		test_random_lines();
		test_timeout_boundary();
		drain_results();

		if (!failed)
			$display("terminated_line_assembler verification clean");
		else
			$display("terminated_line_assembler verification failed");
		$finish;
	end
endmodule
